// ===== rtl/rtt_aimd_pkg.sv =====
package rtt_aimd_pkg;

  localparam logic [15:0] MSS_RESET = 16'd1460;
  localparam logic [15:0] THR_RESET = 16'd205;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [7:0] GROWTH_LIMIT = 8'd5;
  localparam logic [7:0] GROWTH_MAX = 8'd255;
  localparam int Q10_SHIFT = 10;
  localparam int DIV_STEPS = 33;
  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  localparam logic CFG_MSS = 1'b0;
  localparam logic CFG_THR = 1'b1;

  typedef enum logic [1:0] {
    REQ_RTT  = 2'd0,
    REQ_INC  = 2'd1,
    REQ_LOSS = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_PROD,
    ST_DIV,
    ST_QUOT,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
    logic prod;
    logic div;
    logic quot;
    logic mul;
    logic add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic slow_start;
    logic cwnd_zero;
    logic div_last;
  } status_t;

endpackage

// ===== rtl/rtt_aimd_ctrl.sv =====
module rtt_aimd_ctrl import rtt_aimd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.req == REQ_INC) begin
          state_next = status.slow_start ? ST_MUL : ST_STEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_STEP: state_next = ST_PROD;
      ST_PROD: state_next = status.cwnd_zero ? ST_MUL : ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.capture = in_valid;
      ST_EXEC: cmd.exec = 1'b1;
      ST_STEP: cmd.step = 1'b1;
      ST_PROD: cmd.prod = 1'b1;
      ST_DIV:  cmd.div = 1'b1;
      ST_QUOT: cmd.quot = 1'b1;
      ST_MUL:  cmd.mul = 1'b1;
      ST_ADD:  cmd.add = 1'b1;
      ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/rtt_aimd_dp.sv =====
module rtt_aimd_dp import rtt_aimd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [31:0] rtt_us,
  input  logic [15:0] segments_acked,
  input  logic [31:0] cwnd_in,
  input  logic [31:0] ssthresh_in,
  input  logic [31:0] bytes_in_flight,
  output logic [31:0] cwnd_out,
  output logic [31:0] ssthresh_out,
  output logic        in_avoidance,
  output logic        slowed_down,
  input  cmd_t        cmd,
  output status_t     status
);

  // configuration
  logic [15:0] mss;
  logic [15:0] thr;

  // per-flow state
  logic [31:0] base_rtt;
  logic [31:0] latest_rtt;
  logic [31:0] previous_cwnd;
  logic [7:0]  growth_count;
  logic        avoidance_flag;

  // captured transaction
  req_t        req_q;
  logic [31:0] rtt_q;
  logic [15:0] segs_q;
  logic [31:0] cwnd_q;
  logic [31:0] ssth_q;
  logic [31:0] flight_q;

  // working registers
  logic [47:0] rise_rhs;
  logic [16:0] step;
  logic [32:0] dq;
  logic [31:0] rem;
  logic [5:0]  div_cnt;
  logic [32:0] adder;
  logic [48:0] mul_res;
  logic [31:0] res_cwnd;
  logic [31:0] res_ssth;
  logic        res_slowed;

  logic        risen;
  logic [7:0]  growth_next;
  logic [16:0] step_next;
  logic [17:0] mss_x3;
  logic [32:0] trial;
  logic        trial_ge;
  logic [49:0] sum;
  logic [16:0] twice_mss;
  logic [31:0] half_flight;

  assign status.req = req_q;
  assign status.slow_start = (cwnd_q < ssth_q);
  assign status.cwnd_zero = (cwnd_q == '0);
  assign status.div_last = (div_cnt == DIV_LAST);

  always_comb begin
    risen = (base_rtt != ALL_ONES32) && (latest_rtt != '0) && (latest_rtt > base_rtt) &&
            ({6'd0, (latest_rtt - base_rtt), {Q10_SHIFT{1'b0}}} > rise_rhs);
    growth_next = growth_count;
    if (cwnd_q == previous_cwnd) begin
      growth_next = '0;
    end else if (cwnd_q > previous_cwnd && growth_count < GROWTH_MAX) begin
      growth_next = growth_count + 8'd1;
    end
    mss_x3 = {2'b00, mss} + {1'b0, mss, 1'b0};
    if (risen) begin
      step_next = {2'b00, mss[15:1]};
    end else if (growth_next > GROWTH_LIMIT) begin
      step_next = mss_x3[17:1];
    end else begin
      step_next = {1'b0, mss};
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial = {rem, dq[32]};
  assign trial_ge = (trial >= {1'b0, cwnd_q});

  assign sum = {18'd0, cwnd_q} + {1'b0, mul_res};
  assign twice_mss = {mss, 1'b0};
  assign half_flight = {1'b0, flight_q[31:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mss <= MSS_RESET;
      thr <= THR_RESET;
      base_rtt <= ALL_ONES32;
      latest_rtt <= ALL_ONES32;
      previous_cwnd <= '0;
      growth_count <= '0;
      avoidance_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MSS: mss <= cfg_data;
          CFG_THR: thr <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (req_q)
          REQ_RTT: begin
            if (rtt_q != '0) begin
              if (rtt_q < base_rtt) begin
                base_rtt <= rtt_q;
              end
              latest_rtt <= rtt_q;
            end
          end
          REQ_INC: begin
            if (cwnd_q < ssth_q) begin
              previous_cwnd <= cwnd_q;
              avoidance_flag <= 1'b0;
            end else begin
              avoidance_flag <= 1'b1;
            end
          end
          REQ_LOSS: growth_count <= '0;
          default: ;
        endcase
      end
      if (cmd.step) begin
        // growth test needs the old window, so in avoidance it is replaced only here
        previous_cwnd <= cwnd_q;
        if (!risen) begin
          growth_count <= growth_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_t'(req_type);
      rtt_q <= rtt_us;
      segs_q <= segments_acked;
      cwnd_q <= cwnd_in;
      ssth_q <= ssthresh_in;
      flight_q <= bytes_in_flight;
    end
    if (cmd.exec) begin
      rise_rhs <= {16'd0, thr} * {16'd0, base_rtt};
      adder <= {17'd0, mss};
      res_cwnd <= cwnd_q;
      res_ssth <= ssth_q;
      res_slowed <= 1'b0;
      if (req_q == REQ_LOSS) begin
        res_ssth <= ({15'd0, twice_mss} > half_flight) ? {15'd0, twice_mss} : half_flight;
      end
    end
    if (cmd.step) begin
      step <= step_next;
      res_slowed <= risen;
    end
    if (cmd.prod) begin
      dq <= {16'd0, step} * {17'd0, mss};
      rem <= '0;
      div_cnt <= '0;
      adder <= (step == '0) ? 33'd1 : {16'd0, step};
    end
    if (cmd.div) begin
      dq <= {dq[31:0], trial_ge};
      rem <= trial_ge ? 32'(trial - {1'b0, cwnd_q}) : trial[31:0];
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.quot) begin
      adder <= (dq == '0) ? 33'd1 : dq;
    end
    if (cmd.mul) begin
      mul_res <= adder * {33'd0, segs_q};
    end
    if (cmd.add) begin
      res_cwnd <= (sum[49:32] != '0) ? ALL_ONES32 : sum[31:0];
    end
    if (cmd.load_out) begin
      cwnd_out <= res_cwnd;
      ssthresh_out <= res_ssth;
      in_avoidance <= avoidance_flag;
      slowed_down <= res_slowed;
    end
  end

endmodule

// ===== rtl/rtt_aware_aimd_cwnd_update_unit.sv =====
// sequence: rtt samples, losses and other request codes go from capture through execute
// to done, slow start steps also multiply and add, and a congestion avoidance step first
// runs the step, product, divide and quotient states (no divide for a zero window)
// throughput: one transaction at a time; the radix-2 window divide sets
// the avoidance rate, a new transaction is taken while a result waits at the output
// reset: synchronous active-high rst restores mss 1460, threshold 205, rtt state
// unset, growth counter and avoidance flag cleared, output empty
module rtt_aware_aimd_cwnd_update_unit import rtt_aimd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] rtt_us,
  input  logic [15:0] segments_acked,
  input  logic [31:0] cwnd_in,
  input  logic [31:0] ssthresh_in,
  input  logic [31:0] bytes_in_flight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] cwnd_out,
  output logic [31:0] ssthresh_out,
  output logic        in_avoidance,
  output logic        slowed_down
);

  cmd_t    cmd;
  status_t status;

  rtt_aimd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rtt_aimd_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .rtt_us          (rtt_us),
    .segments_acked  (segments_acked),
    .cwnd_in         (cwnd_in),
    .ssthresh_in     (ssthresh_in),
    .bytes_in_flight (bytes_in_flight),
    .cwnd_out        (cwnd_out),
    .ssthresh_out    (ssthresh_out),
    .in_avoidance    (in_avoidance),
    .slowed_down     (slowed_down),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// ===== rtl/rtt_aimd_chk.sv =====
module rtt_aimd_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] cwnd_out,
  input logic [31:0] ssthresh_out,
  input logic        in_avoidance,
  input logic        slowed_down
);

  // one transaction in flight: the input closes right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // the halved step exists only in congestion avoidance
  a_slowed_in_avoid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && slowed_down) |-> in_avoidance)
    else $error("slowed step reported outside avoidance");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cwnd_out) && $stable(ssthresh_out)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("reset did not empty the unit");

endmodule

bind rtt_aware_aimd_cwnd_update_unit rtt_aimd_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cwnd_out     (cwnd_out),
  .ssthresh_out (ssthresh_out),
  .in_avoidance (in_avoidance),
  .slowed_down  (slowed_down)
);
